>>> hw/rtl/pmq_pkg.sv
// package: types and constants for the priority message queue
package pmq_pkg;

  localparam int unsigned QueueDepth     = 64;
  localparam int unsigned IdxW           = $clog2(QueueDepth);
  localparam int unsigned OccW           = $clog2(QueueDepth + 1);
  localparam int unsigned TicksPerSecond = 1000000;
  localparam int unsigned TotalW         = 30;
  localparam int unsigned StampW         = 48;
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned CfgDataW       = 30;
  localparam int unsigned DivW           = 40;

  // time level divides by 2*TicksPerSecond: a shift by TimeShiftLo, then a
  // reciprocal multiply that is exact for a 21-bit shifted value
  localparam int unsigned     TimeShiftLo    = 7;
  localparam longint unsigned TimeDivHi      = (2 * TicksPerSecond) >> TimeShiftLo;
  localparam int unsigned     TimeRecipShift = 35;
  localparam logic [21:0]     TimeRecip      =
      22'(((64'd1 << TimeRecipShift) + TimeDivHi - 1) / TimeDivHi);

  typedef enum logic [1:0] {
    ActPut   = 2'd0,
    ActGet   = 2'd1,
    ActFlush = 2'd2,
    ActCount = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StNoInit  = 3'd1,
    StNothing = 3'd2,
    StAbort   = 3'd3,
    StFull    = 3'd4
  } status_e;

  localparam logic [CfgIdxW-1:0] CfgEnabled = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAbort   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxSize = 2'd2;

  localparam logic [3:0] TypePacket = 4'd1;
  localparam logic [3:0] TypeAll    = 4'd0;

  typedef struct packed {
    logic [1:0]         action;
    logic [15:0]        handle;
    logic [3:0]         priority_req;
    logic [3:0]         message_type;
    logic [23:0]        packet_size;
    logic signed [47:0] dts;
    logic               dts_valid;
    logic signed [47:0] pts;
    logic               pts_valid;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_handle;
    logic [3:0]  out_priority;
    logic [3:0]  out_type;
    logic [6:0]  type_count;
    logic [6:0]  fill_level;
  } out_item_t;

  // one slot of the queue: key fields, packet bytes, stamp with valid on top
  typedef struct packed {
    logic [15:0]     handle;
    logic [3:0]      prio;
    logic [3:0]      mtype;
    logic [23:0]     bytes;
    logic [StampW:0] stamp;
  } entry_t;

endpackage

>>> hw/rtl/priority_message_queue_with_fill_level.sv
// top level: sorted priority message queue with a fill level
//
// Input channel in_valid_i/in_ready_o carries one action item (put, get,
// flush by type, count by type); output channel out_valid_o/out_ready_i
// returns exactly one result item per input item. Config writes go through
// cfg_we_i/cfg_idx_i/cfg_data_i and are applied at once.
//
// The queue lives in a memory with one read and one write port. A shared
// slot-move/scan unit walks the slots, a read state then a write state per
// slot: a put moves each slot of equal or higher priority up by one, a
// flush compacts surviving slots, an enabled count scans all slots. A get
// reads the top slot. A byte based level then runs a bit-serial divider,
// one quotient bit a cycle. The input is not ready while an item is being
// worked on. Reset empties the queue, clears the byte total and both
// stamps, and loads the register defaults. A finished result stays in the
// output register until taken; the next item is accepted in the same cycle
// it is taken.
module priority_message_queue_with_fill_level (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  pmq_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output pmq_pkg::out_item_t              out_data_o,
  input  logic                            cfg_we_i,
  input  logic [pmq_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [pmq_pkg::CfgDataW-1:0]    cfg_data_i
);

  typedef enum logic [9:0] {
    SIdle   = 10'b0000000001,
    SPutRd  = 10'b0000000010,
    SPutWr  = 10'b0000000100,
    SScanRd = 10'b0000001000,
    SScanWr = 10'b0000010000,
    SGetRd  = 10'b0000100000,
    SGetWr  = 10'b0001000000,
    SLevel  = 10'b0010000000,
    SDiv    = 10'b0100000000,
    STime   = 10'b1000000000
  } state_e;

  localparam int unsigned IdxW = pmq_pkg::IdxW;
  localparam int unsigned OccW = pmq_pkg::OccW;
  localparam int unsigned DivW = pmq_pkg::DivW;
  localparam int unsigned SW   = pmq_pkg::StampW;

  state_e state_q, state_d;

  logic                   enabled_q;
  logic                   abort_q;
  logic [29:0]            max_size_q;

  pmq_pkg::entry_t        mem_q [pmq_pkg::QueueDepth];
  pmq_pkg::entry_t        rd_q;
  logic [IdxW-1:0]        rd_addr;
  logic                   wr_en;
  logic [IdxW-1:0]        wr_addr;
  pmq_pkg::entry_t        wr_data;

  logic [OccW-1:0]        occ_q, occ_d;
  logic [29:0]            total_q, total_d;
  logic [SW:0]            front_q, front_d, back_q, back_d;

  pmq_pkg::in_item_t      item_q;
  logic [SW:0]            istamp;
  logic [OccW-1:0]        ptr_q, ptr_d;   // read pointer of the scan
  logic [OccW-1:0]        wptr_q, wptr_d; // write pointer of flush compaction
  logic [6:0]             cnt_q, cnt_d;
  logic [2:0]             status_q, status_d;
  logic [15:0]            oh_q, oh_d;
  logic [3:0]             op_q, op_d;
  logic [3:0]             ot_q, ot_d;

  // bit-serial divider
  logic [DivW-1:0]        num_q, num_d;
  logic [DivW-1:0]        den_q, den_d;
  logic [DivW:0]          rem_q, rem_d;
  logic [DivW-1:0]        quo_q, quo_d;
  logic [5:0]             dcnt_q, dcnt_d;
  logic [6:0]             level_q, level_d;
  logic [DivW:0]          rem_sh;

  // time level: shift then reciprocal multiply
  logic [20:0]            tlo;
  logic [42:0]            tprod;
  logic [7:0]             tlevel;

  logic                   out_valid_q;
  logic                   take_in;

  // level inputs
  logic signed [SW:0]     fdiff;
  logic                   time_based;
  logic [SW:0]            dmag;

  assign in_ready_o  = (state_q == SIdle) && (!out_valid_q || out_ready_i);
  assign take_in     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = '{status: status_q, out_handle: oh_q, out_priority: op_q,
                         out_type: ot_q, type_count: cnt_q, fill_level: level_q};

  always_comb begin
    if (item_q.dts_valid) istamp = {1'b1, item_q.dts};
    else if (item_q.pts_valid) istamp = {1'b1, item_q.pts};
    else istamp = '0;
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q  <= 1'b0;
      abort_q    <= 1'b0;
      max_size_q <= 30'd1048576;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pmq_pkg::CfgEnabled: enabled_q  <= cfg_data_i[0];
        pmq_pkg::CfgAbort:   abort_q    <= cfg_data_i[0];
        pmq_pkg::CfgMaxSize: max_size_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // memory
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rd_q <= mem_q[rd_addr];
  end

  assign fdiff      = $signed({front_q[SW-1], front_q[SW-1:0]}) -
                      $signed({back_q[SW-1], back_q[SW-1:0]});
  assign time_based = front_q[SW] && back_q[SW] && (fdiff > 0);
  assign dmag       = fdiff;
  assign rem_sh     = {rem_q[DivW-1:0], num_q[DivW-1]};
  assign tlo        = num_q[pmq_pkg::TimeShiftLo +: 21];
  assign tprod      = 43'(tlo) * 43'(pmq_pkg::TimeRecip);
  assign tlevel     = tprod[pmq_pkg::TimeRecipShift +: 8];

  always_comb begin
    state_d  = state_q;
    occ_d    = occ_q;
    total_d  = total_q;
    front_d  = front_q;
    back_d   = back_q;
    ptr_d    = ptr_q;
    wptr_d   = wptr_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    oh_d     = oh_q;
    op_d     = op_q;
    ot_d     = ot_q;
    num_d    = num_q;
    den_d    = den_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    dcnt_d   = dcnt_q;
    level_d  = level_q;
    rd_addr  = ptr_q[IdxW-1:0];
    wr_en    = 1'b0;
    wr_addr  = ptr_q[IdxW-1:0];
    wr_data  = rd_q;
    case (state_q)
      SIdle: begin
        if (take_in) begin
          status_d = pmq_pkg::StOk;
          oh_d     = '0;
          op_d     = '0;
          ot_d     = '0;
          cnt_d    = '0;
          ptr_d    = occ_q;
          wptr_d   = '0;
          state_d  = SLevel;
          case (in_data_i.action)
            pmq_pkg::ActPut: begin
              if (!enabled_q) status_d = pmq_pkg::StNoInit;
              else if (occ_q >= OccW'(pmq_pkg::QueueDepth)) status_d = pmq_pkg::StFull;
              else state_d = SPutRd;
            end
            pmq_pkg::ActGet: begin
              if (!enabled_q) status_d = pmq_pkg::StNoInit;
              else if (abort_q) status_d = pmq_pkg::StAbort;
              else if (occ_q == '0) status_d = pmq_pkg::StNothing;
              else begin
                ptr_d   = occ_q - 1'b1;
                state_d = SGetRd;
              end
            end
            pmq_pkg::ActFlush: begin
              ptr_d   = '0;
              state_d = SScanRd;
            end
            default: begin
              ptr_d   = '0;
              if (enabled_q) state_d = SScanRd;
            end
          endcase
        end
      end
      // ptr points at the free slot; read the one below it
      SPutRd: begin
        rd_addr = IdxW'(ptr_q - 1'b1);
        if (ptr_q == '0) state_d = SPutWr;
        else state_d = SPutWr;
      end
      SPutWr: begin
        wr_en = 1'b1;
        if (ptr_q != '0 && item_q.priority_req <= rd_q.prio) begin
          wr_data = rd_q;
          ptr_d   = ptr_q - 1'b1;
          state_d = SPutRd;
        end else begin
          wr_data = '{handle: item_q.handle, prio: item_q.priority_req,
                      mtype: item_q.message_type,
                      bytes: (item_q.message_type == pmq_pkg::TypePacket) ?
                             item_q.packet_size : 24'd0,
                      stamp: istamp};
          occ_d = occ_q + 1'b1;
          if (item_q.message_type == pmq_pkg::TypePacket) begin
            if ({1'b0, total_q} + 31'(item_q.packet_size) > 31'h3FFFFFFF)
              total_d = 30'h3FFFFFFF;
            else total_d = total_q + 30'(item_q.packet_size);
            if (istamp[SW]) front_d = istamp;
            if (!back_q[SW]) back_d = istamp[SW] ? istamp : front_q;
          end
          state_d = SLevel;
        end
      end
      SGetRd: begin
        state_d = SGetWr;
      end
      SGetWr: begin
        if (rd_q.prio < item_q.priority_req) status_d = pmq_pkg::StNothing;
        else begin
          oh_d  = rd_q.handle;
          op_d  = rd_q.prio;
          ot_d  = rd_q.mtype;
          occ_d = occ_q - 1'b1;
          if (rd_q.mtype == pmq_pkg::TypePacket) begin
            total_d = (total_q > 30'(rd_q.bytes)) ? total_q - 30'(rd_q.bytes) : '0;
            if (rd_q.stamp[SW]) back_d = rd_q.stamp;
          end
        end
        state_d = SLevel;
      end
      SScanRd: begin
        if (ptr_q >= occ_q) begin
          if (item_q.action == pmq_pkg::ActFlush) begin
            occ_d = wptr_q;
            if (item_q.message_type == pmq_pkg::TypeAll ||
                item_q.message_type == pmq_pkg::TypePacket) begin
              total_d = '0;
              front_d = '0;
              back_d  = '0;
            end
          end
          state_d = SLevel;
        end else state_d = SScanWr;
      end
      SScanWr: begin
        if (item_q.action == pmq_pkg::ActFlush) begin
          if (item_q.message_type != pmq_pkg::TypeAll &&
              rd_q.mtype != item_q.message_type) begin
            wr_en   = 1'b1;
            wr_addr = wptr_q[IdxW-1:0];
            wptr_d  = wptr_q + 1'b1;
          end
        end else if (rd_q.mtype == item_q.message_type) cnt_d = cnt_q + 1'b1;
        ptr_d   = ptr_q + 1'b1;
        state_d = SScanRd;
      end
      SLevel: begin
        // set up 100*total/max, or 50*d + T for the time level
        rem_d  = '0;
        quo_d  = '0;
        dcnt_d = 6'(DivW);
        if (total_q > max_size_q) begin
          level_d = 7'd100;
          state_d = SIdle;
        end else if (total_q == '0) begin
          level_d = 7'd0;
          state_d = SIdle;
        end else if (time_based) begin
          // a gap over ~5 s saturates anyway
          if (dmag > 49'(pmq_pkg::TicksPerSecond * 5)) begin
            level_d = 7'd100;
            state_d = SIdle;
          end else begin
            num_d   = DivW'(dmag) * DivW'(50) + DivW'(pmq_pkg::TicksPerSecond);
            state_d = STime;
          end
        end else begin
          num_d   = DivW'(total_q) * DivW'(100);
          den_d   = DivW'(max_size_q);
          state_d = SDiv;
        end
      end
      STime: begin
        level_d = (tlevel > 8'd100) ? 7'd100 : tlevel[6:0];
        state_d = SIdle;
      end
      SDiv: begin
        num_d = {num_q[DivW-2:0], 1'b0};
        if (rem_sh >= {1'b0, den_q}) begin
          rem_d = rem_sh - {1'b0, den_q};
          quo_d = {quo_q[DivW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[DivW-2:0], 1'b0};
        end
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == 6'd1) begin
          level_d = (quo_d > DivW'(100)) ? 7'd100 : quo_d[6:0];
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      occ_q       <= '0;
      total_q     <= '0;
      front_q     <= '0;
      back_q      <= '0;
      out_valid_q <= 1'b0;
      dcnt_q      <= '0;
      ptr_q       <= '0;
      wptr_q      <= '0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      total_q <= total_d;
      front_q <= front_d;
      back_q  <= back_d;
      dcnt_q  <= dcnt_d;
      ptr_q   <= ptr_d;
      wptr_q  <= wptr_d;
      if (state_q != SIdle && state_d == SIdle) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) item_q <= in_data_i;
    cnt_q    <= cnt_d;
    status_q <= status_d;
    oh_q     <= oh_d;
    op_q     <= op_d;
    ot_q     <= ot_d;
    num_q    <= num_d;
    den_q    <= den_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    level_q  <= level_d;
  end

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(pmq_pkg::QueueDepth))
    else $error("occupancy above depth");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> !in_ready_o)
    else $error("ready while busy");
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle && state_d == SIdle) |=> out_valid_o)
    else $error("result not shown");
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> level_q <= 7'd100)
    else $error("level above 100");
`endif

endmodule

>>> tb/tb_top.sv
// testbench for the priority message queue with a fill level
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CycleLimit = 3000000;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  pmq_pkg::in_item_t            in_data_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  pmq_pkg::out_item_t           out_data_o;
  logic                         cfg_we_i;
  logic [pmq_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [pmq_pkg::CfgDataW-1:0] cfg_data_i;

  priority_message_queue_with_fill_level i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // model of the queue, slot 0 lowest priority, top slot popped
  pmq_pkg::entry_t slots_q[$];
  logic [29:0]  byte_total;
  logic [48:0]  front_stamp;
  logic [48:0]  back_stamp;
  logic         en_reg;
  logic         abort_reg;
  logic [29:0]  max_size_reg;

  pmq_pkg::out_item_t pending_q[$];
  int unsigned  err_cnt;
  longint unsigned cycle_cnt;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [6:0] level_now();
    longint signed   f;
    longint signed   b;
    longint unsigned d;
    longint unsigned lvl;
    if (byte_total > max_size_reg) return 7'd100;
    if (byte_total == 0) return 7'd0;
    if (front_stamp[48] && back_stamp[48]) begin
      f = longint'($signed(front_stamp[47:0]));
      b = longint'($signed(back_stamp[47:0]));
      if (f > b) begin
        d = longint'(f - b);
        lvl = (50 * d + pmq_pkg::TicksPerSecond) / (2 * pmq_pkg::TicksPerSecond);
        return (lvl > 100) ? 7'd100 : 7'(lvl);
      end
    end
    lvl = (longint'(100) * byte_total) / max_size_reg;
    return (lvl > 100) ? 7'd100 : 7'(lvl);
  endfunction

  function automatic pmq_pkg::out_item_t predict_action(pmq_pkg::in_item_t it);
    pmq_pkg::out_item_t r;
    pmq_pkg::entry_t    e;
    logic [48:0]        stamp;
    longint unsigned    sum;
    int                 pos;
    pmq_pkg::entry_t    kept_q[$];
    r = '0;
    stamp = '0;
    if (it.dts_valid) stamp = {1'b1, it.dts};
    else if (it.pts_valid) stamp = {1'b1, it.pts};
    case (pmq_pkg::action_e'(it.action))
      pmq_pkg::ActPut: begin
        if (!en_reg) r.status = pmq_pkg::StNoInit;
        else if (slots_q.size() >= pmq_pkg::QueueDepth) r.status = pmq_pkg::StFull;
        else begin
          pos = 0;
          while (pos < slots_q.size() && it.priority_req > slots_q[pos].prio) pos++;
          e.handle = it.handle;
          e.prio   = it.priority_req;
          e.mtype  = it.message_type;
          e.bytes  = (it.message_type == pmq_pkg::TypePacket) ? it.packet_size : '0;
          e.stamp  = stamp;
          slots_q.insert(pos, e);
          if (it.message_type == pmq_pkg::TypePacket) begin
            sum = longint'(byte_total) + it.packet_size;
            byte_total = (sum > 30'h3fffffff) ? 30'h3fffffff : 30'(sum);
            if (stamp[48]) front_stamp = stamp;
            if (!back_stamp[48]) back_stamp = front_stamp;
          end
        end
      end
      pmq_pkg::ActGet: begin
        if (!en_reg) r.status = pmq_pkg::StNoInit;
        else if (abort_reg) r.status = pmq_pkg::StAbort;
        else if (slots_q.size() == 0 || slots_q[$].prio < it.priority_req)
          r.status = pmq_pkg::StNothing;
        else begin
          e = slots_q[slots_q.size() - 1];
          slots_q.delete(slots_q.size() - 1);
          if (e.mtype == pmq_pkg::TypePacket) begin
            byte_total = (byte_total > e.bytes) ? byte_total - e.bytes : '0;
            if (e.stamp[48]) back_stamp = e.stamp;
          end
          r.out_handle   = e.handle;
          r.out_priority = e.prio;
          r.out_type     = e.mtype;
        end
      end
      pmq_pkg::ActFlush: begin
        foreach (slots_q[k])
          if (it.message_type != pmq_pkg::TypeAll && slots_q[k].mtype != it.message_type)
            kept_q.push_back(slots_q[k]);
        slots_q = kept_q;
        if (it.message_type == pmq_pkg::TypeAll || it.message_type == pmq_pkg::TypePacket)
        begin
          byte_total = '0;
          front_stamp = '0;
          back_stamp = '0;
        end
      end
      default: begin
        if (en_reg)
          foreach (slots_q[k])
            if (slots_q[k].mtype == it.message_type) r.type_count++;
      end
    endcase
    r.fill_level = level_now();
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    pmq_pkg::out_item_t exp_r;
    if (out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $error("result with no item pending");
        err_cnt++;
      end else begin
        exp_r = pending_q.pop_front();
        if (out_data_o.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, out_data_o.status); err_cnt++;
        end
        if (out_data_o.out_handle !== exp_r.out_handle) begin
          $error("out_handle exp %0h got %0h", exp_r.out_handle, out_data_o.out_handle);
          err_cnt++;
        end
        if (out_data_o.out_priority !== exp_r.out_priority) begin
          $error("out_priority exp %0d got %0d", exp_r.out_priority,
                 out_data_o.out_priority);
          err_cnt++;
        end
        if (out_data_o.out_type !== exp_r.out_type) begin
          $error("out_type exp %0d got %0d", exp_r.out_type, out_data_o.out_type);
          err_cnt++;
        end
        if (out_data_o.type_count !== exp_r.type_count) begin
          $error("type_count exp %0d got %0d", exp_r.type_count, out_data_o.type_count);
          err_cnt++;
        end
        if (out_data_o.fill_level !== exp_r.fill_level) begin
          $error("fill_level exp %0d got %0d", exp_r.fill_level, out_data_o.fill_level);
          err_cnt++;
        end
      end
    end
  end

  // receiver stalls: a random wait, sometimes none, after each accept
  initial begin
    int gap;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ready_i && out_valid_o) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // valid stays high into the next item when there is no gap
  task automatic send_item(pmq_pkg::in_item_t it, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    pending_q.push_back(predict_action(it));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_queue();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [pmq_pkg::CfgIdxW-1:0] idx,
                           logic [pmq_pkg::CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pmq_pkg::CfgEnabled: en_reg = val[0];
      pmq_pkg::CfgAbort:   abort_reg = val[0];
      default:             max_size_reg = val;
    endcase
    @(posedge clk_i);
  endtask

  function automatic pmq_pkg::in_item_t make_item(pmq_pkg::action_e act, logic [3:0] prio,
                                                  logic [3:0] mt);
    pmq_pkg::in_item_t it;
    it.action       = act;
    it.handle       = 16'($urandom);
    it.priority_req = prio;
    it.message_type = mt;
    it.packet_size  = ($urandom_range(0, 3) == 0) ? 24'($urandom) :
                      24'($urandom_range(0, 4000));
    it.dts          = ($urandom_range(0, 7) == 0) ? 48'({$urandom, $urandom}) :
                      48'($urandom_range(0, 8000000));
    it.pts          = ($urandom_range(0, 7) == 0) ? 48'({$urandom, $urandom}) :
                      48'($urandom_range(0, 8000000));
    it.dts_valid    = 1'($urandom_range(0, 1));
    it.pts_valid    = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic test_disabled();
    send_item(make_item(pmq_pkg::ActPut, 4'd3, pmq_pkg::TypePacket));
    send_item(make_item(pmq_pkg::ActGet, 4'd0, 4'd0));
    send_item(make_item(pmq_pkg::ActCount, 4'd0, pmq_pkg::TypePacket));
    send_item(make_item(pmq_pkg::ActFlush, 4'd0, 4'd5));
    drain_queue();
  endtask

  task automatic test_extremes();
    pmq_pkg::in_item_t it;
    write_reg(pmq_pkg::CfgEnabled, 30'd1);
    it = make_item(pmq_pkg::ActPut, 4'd15, pmq_pkg::TypePacket);
    it.handle = 16'hffff; it.packet_size = 24'hffffff;
    it.dts = 48'h7fffffffffff; it.dts_valid = 1'b1;
    send_item(it);
    it = make_item(pmq_pkg::ActPut, 4'd0, pmq_pkg::TypePacket);
    it.handle = 16'h0; it.packet_size = 24'h0;
    it.dts = 48'h800000000000; it.dts_valid = 1'b1;
    send_item(it);
    it = make_item(pmq_pkg::ActPut, 4'd7, 4'd15);
    it.dts_valid = 1'b0; it.pts_valid = 1'b1;
    send_item(it);
    send_item(make_item(pmq_pkg::ActCount, 4'd0, pmq_pkg::TypePacket));
    send_item(make_item(pmq_pkg::ActGet, 4'd15, 4'd0));
    send_item(make_item(pmq_pkg::ActGet, 4'd15, 4'd0));
    send_item(make_item(pmq_pkg::ActGet, 4'd0, 4'd0));
    drain_queue();
    write_reg(pmq_pkg::CfgAbort, 30'd1);
    send_item(make_item(pmq_pkg::ActGet, 4'd0, 4'd0));
    drain_queue();
    write_reg(pmq_pkg::CfgAbort, 30'd0);
    write_reg(pmq_pkg::CfgMaxSize, 30'd0);
    send_item(make_item(pmq_pkg::ActPut, 4'd2, pmq_pkg::TypePacket));
    send_item(make_item(pmq_pkg::ActFlush, 4'd0, pmq_pkg::TypeAll));
    drain_queue();
    write_reg(pmq_pkg::CfgMaxSize, 30'h3fffffff);
    // fill past depth to reach full status
    for (int k = 0; k < pmq_pkg::QueueDepth + 2; k++)
      send_item(make_item(pmq_pkg::ActPut, 4'($urandom), pmq_pkg::TypePacket), 1);
    send_item(make_item(pmq_pkg::ActCount, 4'd0, pmq_pkg::TypePacket));
    send_item(make_item(pmq_pkg::ActFlush, 4'd0, pmq_pkg::TypePacket));
    drain_queue();
  endtask

  task automatic test_random(int unsigned n_items);
    pmq_pkg::in_item_t it;
    int unsigned r;
    for (int unsigned k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45) it = make_item(pmq_pkg::ActPut, 4'($urandom), 4'($urandom_range(0, 3)));
      else if (r < 85)
        it = make_item(pmq_pkg::ActGet,
                       4'($urandom_range(0, 15)) & 4'(r[0] ? 4'hf : 4'h3), 4'($urandom));
      else if (r < 90)
        it = make_item(pmq_pkg::ActFlush, 4'($urandom), 4'($urandom_range(0, 4)));
      else it = make_item(pmq_pkg::ActCount, 4'($urandom), 4'($urandom));
      send_item(it);
    end
    drain_queue();
  endtask

  initial begin
    cycle_cnt  = 0;
    err_cnt    = 0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = pmq_pkg::CfgEnabled;
    cfg_data_i = '0;
    byte_total = '0;
    front_stamp = '0;
    back_stamp = '0;
    en_reg = 1'b0;
    abort_reg = 1'b0;
    max_size_reg = 30'd1048576;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_disabled();
    test_extremes();
    write_reg(pmq_pkg::CfgMaxSize, 30'd1);
    test_random(300);
    write_reg(pmq_pkg::CfgMaxSize, 30'($urandom_range(1000, 200000)));
    test_random(500);
    write_reg(pmq_pkg::CfgEnabled, 30'd0);
    test_random(50);
    write_reg(pmq_pkg::CfgEnabled, 30'd1);
    write_reg(pmq_pkg::CfgMaxSize, 30'd1048576);
    test_random(600);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
